// File: design/andl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the annex b nal delimiter
package andl_pkg;

   localparam int OUT_W       = 32;
   localparam int TYPE_W      = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TYPE_W-1:0] SPS_TYPE = 5'd7;
   localparam logic [TYPE_W-1:0] PPS_TYPE = 5'd8;

   // distance back from the current byte to the leading zero of a code
   localparam int SHORT_LEAD = 2;
   localparam int LONG_LEAD  = 3;

   typedef struct packed {
      logic              nal_valid;
      logic [OUT_W-1:0]  nal_offset;
      logic [OUT_W-1:0]  nal_end;
      logic [TYPE_W-1:0] nal_type;
      logic              first_sps;
      logic              first_pps;
      logic              end_of_buffer;
      logic              converted_ok;
      logic              sets_found;
   } desc_type;

endpackage

// File: design/andl_front.sv
`timescale 1ns / 1ps
// byte scanner: finds start codes and builds nal descriptors
module andl_front #(
   parameter int POS_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               q_full,
   output logic               q_push,
   output andl_pkg::desc_type q_desc
);
   import andl_pkg::*;

   localparam logic [POS_BITS-1:0] PosMax = '1;

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [23:0]         recent_ff, recent_in;
   logic [1:0]          fill_ff, fill_in;
   logic                in_nal_ff, in_nal_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [TYPE_W-1:0]   kind_ff, kind_in;
   logic                sps_ff, sps_in;
   logic                pps_ff, pps_in;
   logic                any_ff, any_in;

   logic                take;
   logic [TYPE_W-1:0]   kind_eff;
   logic                found;
   logic                four;
   logic [POS_BITS-1:0] code_at;
   logic [POS_BITS-1:0] pos_next;
   logic                emit_mid;
   logic                emit_end;
   logic                nal_hit;
   logic                fs;
   logic                fp;
   logic                sps_upd;
   logic                pps_upd;
   logic                any_upd;
   logic [POS_BITS+OUT_W-1:0] start_ext;
   logic [POS_BITS+OUT_W-1:0] end_ext;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      // the first byte after a code carries the nal type
      kind_eff = (in_nal_ff && fill_ff == 2'd0) ? req_data_byte[TYPE_W-1:0] : kind_ff;
      found    = (req_data_byte == 8'h01) && (recent_ff[15:0] == 16'h0000) &&
                 (fill_ff >= 2'd2);
      four     = (recent_ff[23:16] == 8'h00) && (fill_ff == 2'd3);
      if (four) begin
         code_at = (pos_ff >= POS_BITS'(LONG_LEAD)) ? pos_ff - POS_BITS'(LONG_LEAD) : '0;
      end else begin
         code_at = (pos_ff >= POS_BITS'(SHORT_LEAD)) ? pos_ff - POS_BITS'(SHORT_LEAD) : '0;
      end
      pos_next = (pos_ff == PosMax) ? pos_ff : pos_ff + 1'b1;
      emit_mid = found && in_nal_ff && (code_at > start_ff);
      emit_end = req_last_byte && !found && in_nal_ff && (pos_next > start_ff);
      nal_hit  = emit_mid || emit_end;
      fs       = nal_hit && (kind_eff == SPS_TYPE) && !sps_ff;
      fp       = nal_hit && (kind_eff == PPS_TYPE) && !pps_ff;
      sps_upd  = sps_ff || fs;
      pps_upd  = pps_ff || fp;
      any_upd  = any_ff || nal_hit;
      start_ext = {{OUT_W{1'b0}}, start_ff};
      end_ext   = emit_mid ? {{OUT_W{1'b0}}, code_at} : {{OUT_W{1'b0}}, pos_next};
   end

   always_comb begin
      q_push               = take && (nal_hit || req_last_byte);
      q_desc.nal_valid     = nal_hit;
      q_desc.nal_offset    = nal_hit ? start_ext[OUT_W-1:0] : '0;
      q_desc.nal_end       = nal_hit ? end_ext[OUT_W-1:0] : '0;
      q_desc.nal_type      = nal_hit ? kind_eff : '0;
      q_desc.first_sps     = fs;
      q_desc.first_pps     = fp;
      q_desc.end_of_buffer = req_last_byte;
      q_desc.converted_ok  = req_last_byte && any_upd;
      q_desc.sets_found    = req_last_byte && sps_upd && pps_upd;
   end

   always_comb begin
      pos_in    = pos_ff;
      recent_in = recent_ff;
      fill_in   = fill_ff;
      in_nal_in = in_nal_ff;
      start_in  = start_ff;
      kind_in   = kind_ff;
      sps_in    = sps_ff;
      pps_in    = pps_ff;
      any_in    = any_ff;
      if (take) begin
         if (req_last_byte) begin
            // buffer closed: back to the reset picture
            pos_in    = '0;
            recent_in = 24'hFFFFFF;
            fill_in   = 2'd0;
            in_nal_in = 1'b0;
            start_in  = '0;
            kind_in   = '0;
            sps_in    = 1'b0;
            pps_in    = 1'b0;
            any_in    = 1'b0;
         end else begin
            pos_in    = pos_next;
            recent_in = {recent_ff[15:0], req_data_byte};
            if (found) begin
               fill_in = 2'd0;
            end else if (fill_ff != 2'd3) begin
               fill_in = fill_ff + 2'd1;
            end
            in_nal_in = in_nal_ff || found;
            start_in  = found ? pos_next : start_ff;
            kind_in   = kind_eff;
            sps_in    = sps_upd;
            pps_in    = pps_upd;
            any_in    = any_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         recent_ff <= 24'hFFFFFF;
         fill_ff   <= 2'd0;
         in_nal_ff <= 1'b0;
         start_ff  <= '0;
         kind_ff   <= '0;
         sps_ff    <= 1'b0;
         pps_ff    <= 1'b0;
         any_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         recent_ff <= recent_in;
         fill_ff   <= fill_in;
         in_nal_ff <= in_nal_in;
         start_ff  <= start_in;
         kind_ff   <= kind_in;
         sps_ff    <= sps_in;
         pps_ff    <= pps_in;
         any_ff    <= any_in;
      end
   end

endmodule

// File: design/andl_queue.sv
`timescale 1ns / 1ps
// short descriptor queue between scanner and output stage
module andl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  andl_pkg::desc_type push_desc,
   input  logic               pop,
   output andl_pkg::desc_type pop_desc,
   output logic               full,
   output logic               empty
);
   import andl_pkg::*;

   desc_type            entry_ff [QUEUE_DEPTH];
   desc_type            entry_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = entry_ff[rd_ptr_ff];
   assign entry_in = push_desc;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// File: design/andl_back.sv
`timescale 1ns / 1ps
// output stage: works out the nal length and holds the result word
module andl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  andl_pkg::desc_type         q_desc,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_nal_valid,
   output logic [andl_pkg::OUT_W-1:0] rsp_nal_offset,
   output logic [andl_pkg::OUT_W-1:0] rsp_nal_length,
   output logic [andl_pkg::TYPE_W-1:0] rsp_nal_type,
   output logic                       rsp_first_sps,
   output logic                       rsp_first_pps,
   output logic                       rsp_end_of_buffer,
   output logic                       rsp_converted_ok,
   output logic                       rsp_sets_found
);
   import andl_pkg::*;

   logic             valid_ff, valid_in;
   desc_type         desc_ff, desc_in;
   logic [OUT_W-1:0] length_ff, length_in;

   // low bits of end minus start give the length modulo the output width
   assign q_pop     = !q_empty && (!valid_ff || rsp_ready);
   assign desc_in   = q_desc;
   assign length_in = q_desc.nal_end - q_desc.nal_offset;

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         desc_ff   <= desc_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_nal_valid     = desc_ff.nal_valid;
   assign rsp_nal_offset    = desc_ff.nal_offset;
   assign rsp_nal_length    = length_ff;
   assign rsp_nal_type      = desc_ff.nal_type;
   assign rsp_first_sps     = desc_ff.first_sps;
   assign rsp_first_pps     = desc_ff.first_pps;
   assign rsp_end_of_buffer = desc_ff.end_of_buffer;
   assign rsp_converted_ok  = desc_ff.converted_ok;
   assign rsp_sets_found    = desc_ff.sets_found;

endmodule

// File: design/annexb_nal_delimiter.sv
`timescale 1ns / 1ps
// annex b start code scanner giving a descriptor word per nal unit and per buffer end
// throughput: one byte per clock while the queue is not full; the scanner
// updates all state on each accepted byte; a result word passes through
// the two-entry queue and then the output register before it shows on rsp
// reset: synchronous, clears scanner state, queue and output; the scanner also
// returns to its reset state after each byte flagged last
module annexb_nal_delimiter #(
   parameter int POS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_nal_valid,
   output logic [31:0] rsp_nal_offset,
   output logic [31:0] rsp_nal_length,
   output logic [4:0]  rsp_nal_type,
   output logic        rsp_first_sps,
   output logic        rsp_first_pps,
   output logic        rsp_end_of_buffer,
   output logic        rsp_converted_ok,
   output logic        rsp_sets_found
);
   import andl_pkg::*;

   logic     q_full;
   logic     q_empty;
   logic     q_push;
   logic     q_pop;
   desc_type push_desc;
   desc_type pop_desc;

   andl_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc)
   );

   andl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   andl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_desc            (pop_desc),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nal_valid     (rsp_nal_valid),
      .rsp_nal_offset    (rsp_nal_offset),
      .rsp_nal_length    (rsp_nal_length),
      .rsp_nal_type      (rsp_nal_type),
      .rsp_first_sps     (rsp_first_sps),
      .rsp_first_pps     (rsp_first_pps),
      .rsp_end_of_buffer (rsp_end_of_buffer),
      .rsp_converted_ok  (rsp_converted_ok),
      .rsp_sets_found    (rsp_sets_found)
   );

endmodule
